// ===== rtl/psp_pkg.sv =====
package psp_pkg;

   // Input transaction: one stream byte or an end-of-buffer marker
   typedef struct packed {
      logic [7:0] data_byte;
      logic       buffer_end;
   } req_type;

   // Result transaction
   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       string_end;
      logic [1:0] status;
   } rsp_type;

   // Status codes
   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_BAD_HEADER = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW   = 2'd2;
   localparam logic [1:0] STATUS_END        = 2'd3;

   // Header bytes
   localparam logic [7:0] HDR_EMPTY  = 8'h00;
   localparam logic [7:0] HDR_LENGTH = 8'h0B;
   localparam logic [7:0] CTRL_LIMIT = 8'h20;

   // ULEB128 group size
   localparam int LEB_GROUP_BITS = 7;

   // One queue entry: the results caused by one input byte (one or two)
   typedef struct packed {
      logic    two;
      rsp_type first;
      rsp_type second;
   } entry_type;

   // Front to back: push of one entry
   typedef struct packed {
      logic      push;
      entry_type entry;
   } push_type;

   // Result queue between front and back
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

endpackage

// ===== rtl/psp_front.sv =====
module psp_front
   import psp_pkg::*;
#(
   parameter int LENGTH_BITS = 32
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  req_type  req_data,
   input  logic     space,
   output push_type push_req
);

   typedef enum logic [3:0] {
      MODE_IDLE = 4'b0001,
      MODE_LEN  = 4'b0010,
      MODE_PAY  = 4'b0100,
      MODE_RAW  = 4'b1000
   } mode_type;

   localparam logic [5:0] LEN_LIMIT = 6'(LENGTH_BITS);
   localparam logic [5:0] GROUP     = 6'(LEB_GROUP_BITS);

   mode_type               mode_ff, mode_in;
   logic [LENGTH_BITS-1:0] len_ff, len_in;
   logic [2:0]             step_ff, step_in;
   logic [LENGTH_BITS-1:0] left_ff, left_in;

   logic                   accept;
   logic [7:0]             b;
   logic                   hdr_emit;
   rsp_type                hdr_rsp;
   mode_type               hdr_mode;
   logic [5:0]             shift_amt;
   logic [5:0]             next_bits;
   logic [LENGTH_BITS-1:0] group_ext;
   logic [LENGTH_BITS-1:0] acc_new;

   assign req_stall = !space;
   assign accept    = req_valid && space;
   assign b         = req_data.data_byte;

   // Header decode, shared by idle state and raw-string termination
   always_comb begin
      hdr_emit = 1'b1;
      hdr_rsp  = '0;
      hdr_mode = MODE_IDLE;
      if (b == HDR_EMPTY) begin
         hdr_rsp.string_end = 1'b1;
      end else if (b == HDR_LENGTH) begin
         hdr_emit = 1'b0;
         hdr_mode = MODE_LEN;
      end else if (b < CTRL_LIMIT) begin
         hdr_rsp.status = STATUS_BAD_HEADER;
      end else begin
         hdr_rsp.out_byte = b;
         hdr_rsp.has_byte = 1'b1;
         hdr_mode         = MODE_RAW;
      end
   end

   // Length group placement and overflow bound
   assign shift_amt = {3'b000, step_ff} * GROUP;
   assign next_bits = ({3'b000, step_ff} + 6'd1) * GROUP;
   assign group_ext = LENGTH_BITS'(b[LEB_GROUP_BITS-1:0]);
   assign acc_new   = len_ff | (group_ext << shift_amt);

   // Parser mode update and result generation
   always_comb begin
      mode_in  = mode_ff;
      len_in   = len_ff;
      step_in  = step_ff;
      left_in  = left_ff;
      push_req = '0;
      case (mode_ff)
         MODE_IDLE: begin
            if (req_data.buffer_end) begin
               push_req.push               = 1'b1;
               push_req.entry.first.status = STATUS_END;
            end else begin
               push_req.push        = hdr_emit;
               push_req.entry.first = hdr_rsp;
               mode_in              = hdr_mode;
               if (b == HDR_LENGTH) begin
                  len_in  = '0;
                  step_in = '0;
               end
            end
         end
         MODE_LEN: begin
            if (req_data.buffer_end) begin
               mode_in                     = MODE_IDLE;
               push_req.push               = 1'b1;
               push_req.entry.first.status = STATUS_END;
            end else begin
               len_in = acc_new;
               if (!b[7]) begin
                  if (acc_new == '0) begin
                     mode_in                         = MODE_IDLE;
                     push_req.push                   = 1'b1;
                     push_req.entry.first.string_end = 1'b1;
                  end else begin
                     left_in = acc_new;
                     mode_in = MODE_PAY;
                  end
               end else begin
                  step_in = step_ff + 3'd1;
                  if (next_bits >= LEN_LIMIT) begin
                     mode_in                     = MODE_IDLE;
                     push_req.push               = 1'b1;
                     push_req.entry.first.status = STATUS_OVERFLOW;
                  end
               end
            end
         end
         MODE_PAY: begin
            push_req.push = 1'b1;
            if (req_data.buffer_end) begin
               mode_in                     = MODE_IDLE;
               push_req.entry.first.status = STATUS_END;
            end else begin
               left_in                       = left_ff - LENGTH_BITS'(1);
               push_req.entry.first.out_byte = b;
               push_req.entry.first.has_byte = 1'b1;
               if (left_ff == LENGTH_BITS'(1)) begin
                  mode_in                         = MODE_IDLE;
                  push_req.entry.first.string_end = 1'b1;
               end
            end
         end
         MODE_RAW: begin
            push_req.push = 1'b1;
            if (req_data.buffer_end) begin
               mode_in                         = MODE_IDLE;
               push_req.entry.first.string_end = 1'b1;
            end else if (b < CTRL_LIMIT) begin
               // close the string, then treat the byte as a header
               push_req.entry.first.string_end = 1'b1;
               push_req.entry.two              = hdr_emit;
               push_req.entry.second           = hdr_rsp;
               mode_in                         = hdr_mode;
               if (b == HDR_LENGTH) begin
                  len_in  = '0;
                  step_in = '0;
               end
            end else begin
               push_req.entry.first.out_byte = b;
               push_req.entry.first.has_byte = 1'b1;
            end
         end
         default: begin
            mode_in = MODE_IDLE;
         end
      endcase
      if (!accept) begin
         mode_in       = mode_ff;
         len_in        = len_ff;
         step_in       = step_ff;
         left_in       = left_ff;
         push_req.push = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         len_ff  <= '0;
         step_ff <= '0;
         left_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         len_ff  <= len_in;
         step_ff <= step_in;
         left_ff <= left_in;
      end
   end

`ifndef NO_ASSERTIONS
   // payload mode always has bytes still to come
   a_pay_left: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_PAY |-> left_ff != '0)
      else $error("payload mode with zero bytes left");

   // the length group never starts at or beyond the length width
   a_shift_range: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_LEN |-> shift_amt < LEN_LIMIT)
      else $error("length shift beyond width");

   // nothing is pushed without room in the queue
   a_push_space: assert property (@(posedge clock) disable iff (reset)
      push_req.push |-> space)
      else $error("push into full queue");
`endif

endmodule

// ===== rtl/psp_back.sv =====
module psp_back
   import psp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  push_type push_req,
   output logic     space,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   entry_type                 queue_mem [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] head_ff, head_in;
   logic [QUEUE_PTR_BITS-1:0] tail_ff, tail_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;
   logic                      second_ff, second_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_data_ff, rsp_data_in;

   entry_type                 head_entry;
   logic                      load;
   logic                      pop;

   assign space      = count_ff != QUEUE_CNT_BITS'(QUEUE_DEPTH);
   assign head_entry = queue_mem[head_ff];
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // Output register: take the next result when empty or being taken
   always_comb begin
      load         = !rsp_valid_ff || !rsp_stall;
      pop          = 1'b0;
      second_in    = second_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load) begin
         rsp_valid_in = count_ff != '0;
         if (count_ff != '0) begin
            if (second_ff) begin
               rsp_data_in = head_entry.second;
               second_in   = 1'b0;
               pop         = 1'b1;
            end else begin
               rsp_data_in = head_entry.first;
               if (head_entry.two) begin
                  second_in = 1'b1;
               end else begin
                  pop = 1'b1;
               end
            end
         end
      end
   end

   // Queue pointers
   always_comb begin
      head_in  = pop ? head_ff + QUEUE_PTR_BITS'(1) : head_ff;
      tail_in  = push_req.push ? tail_ff + QUEUE_PTR_BITS'(1) : tail_ff;
      count_in = count_ff + QUEUE_CNT_BITS'(push_req.push) - QUEUE_CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_req.push) begin
         queue_mem[tail_ff] <= push_req.entry;
      end
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         second_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         second_ff    <= second_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef NO_ASSERTIONS
   // fill level stays within the queue
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_BITS'(QUEUE_DEPTH))
      else $error("queue overfilled");

   // a pending second result always has its entry at the head
   a_second_entry: assert property (@(posedge clock) disable iff (reset)
      second_ff |-> count_ff != '0 && head_entry.two)
      else $error("second result without entry");

   // pointers and fill level agree
   a_ptr_count: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH)) |-> head_ff == tail_ff)
      else $error("queue pointers inconsistent");
`endif

endmodule

// ===== rtl/prefixed_string_stream_parser_core.sv =====
// Length-prefixed string stream parser.
// req channel: one transaction per stream byte (data_byte), or an
//   end-of-buffer marker (buffer_end set, data_byte ignored).
// rsp channel: one transaction per string character, string end marker or
//   status; a control byte that closes a raw string and is not a length
//   header gives two transactions.
// Throughput: one request transaction per cycle while the result side keeps
//   up; a byte with two results holds the result side for both of them and the
//   four-entry result queue absorbs it. The single result register, moving
//   one transaction per cycle while rsp_stall is low, sets the sustained rate.
// Path: a result is written into the queue and then registered in the output
//   register, also when the queue is empty.
// Stall: a stalled result holds in the output register; the parser keeps
//   taking bytes until the queue is full, then raises req_stall.
// Reset: synchronous; the parser waits for a header, the queue is empty and
//   rsp_valid is low.
module prefixed_string_stream_parser_core
   import psp_pkg::*;
#(
   parameter int LENGTH_BITS = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   push_type push_req;
   logic     space;

   psp_front #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .space    (space),
      .push_req (push_req)
   );

   psp_back u_back (
      .clock    (clock),
      .reset    (reset),
      .push_req (push_req),
      .space    (space),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

endmodule
